>>> hdl/fixed_width_histogram_unit_assert.svh
// Assertion macros for the histogram RTL; only fwh_back includes them.
// Each expects i_clk and i_rst_n in the enclosing module.
`ifndef FIXED_WIDTH_HISTOGRAM_UNIT_ASSERT_SVH
`define FIXED_WIDTH_HISTOGRAM_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FWH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("histogram assertion failed");

// Next-cycle implication.
`define FWH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("histogram assertion failed");

`endif

>>> hdl/fwh_pkg.sv
package fwh_pkg;

    localparam int NUM_BINS        = 1024;
    localparam int SAMPLE_RANGE    = 10000;
    localparam int BIN_AW          = $clog2(NUM_BINS);
    localparam int SAMPLE_W        = 14;
    localparam int BIN_IDX_W       = 10;
    localparam int COUNT_W         = 32;
    localparam int STEP_W          = $clog2(SAMPLE_W);
    localparam int QDEPTH          = 2;
    localparam int QPTR_W          = $clog2(QDEPTH);
    localparam int QCNT_W          = $clog2(QDEPTH + 1);
    localparam logic [SAMPLE_W-1:0] BIN_WIDTH_RESET = SAMPLE_W'(100);

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [SAMPLE_W-1:0]  sample_value;
        logic [BIN_IDX_W-1:0] read_bin;
    } t_in_item;

    typedef struct packed {
        logic [BIN_IDX_W-1:0] bin_index;
        logic [COUNT_W-1:0]   bin_count;
        logic                 saturated;
    } t_out_item;

    // Classified command handed from front to back.
    typedef struct packed {
        logic                 is_add;
        logic                 in_range;
        logic [BIN_IDX_W-1:0] bin_index;
        logic [BIN_AW-1:0]    addr;
    } t_job;

endpackage

>>> hdl/fwh_front.sv
module fwh_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fwh_pkg::SAMPLE_W-1:0]  i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  fwh_pkg::t_in_item             i_item,
    input  logic                          i_clearing,
    output logic                          o_job_push,
    output fwh_pkg::t_job                 o_job,
    input  logic                          i_job_full
);
    import fwh_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SEND} t_state;

    t_state                r_state;
    logic [SAMPLE_W-1:0]   r_bin_width;
    logic [SAMPLE_W-1:0]   r_div;
    logic [SAMPLE_W-1:0]   r_rem;
    logic [SAMPLE_W-1:0]   r_quo;
    logic [STEP_W-1:0]     r_step;
    t_job                  r_job;

    logic [SAMPLE_W-1:0]   n_sample;
    logic [SAMPLE_W:0]     n_trial;
    logic                  n_bit;
    logic [SAMPLE_W-1:0]   n_rem;
    logic [SAMPLE_W-1:0]   n_quo;
    logic [SAMPLE_W-1:0]   n_bin;
    logic                  accept;

    assign o_cfg_ready = 1'b1;
    assign full        = (r_state != S_IDLE) || i_clearing;
    assign accept      = push && !full;
    assign o_job_push  = (r_state == S_SEND) && !i_job_full;
    assign o_job       = r_job;

    // clamp out-of-range samples to the top of the range
    assign n_sample = (32'(i_item.sample_value) >= SAMPLE_RANGE)
                    ? SAMPLE_W'(SAMPLE_RANGE - 1) : i_item.sample_value;

    // restoring divide, one quotient bit per cycle, MSB first
    assign n_trial = {r_rem, r_quo[SAMPLE_W-1]};
    assign n_bit   = (n_trial >= {1'b0, r_div});
    assign n_rem   = n_bit ? SAMPLE_W'(n_trial - {1'b0, r_div}) : n_trial[SAMPLE_W-1:0];
    assign n_quo   = {r_quo[SAMPLE_W-2:0], n_bit};
    assign n_bin   = (32'(n_quo) >= NUM_BINS) ? SAMPLE_W'(NUM_BINS - 1) : n_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bin_width <= BIN_WIDTH_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_bin_width <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_item.cmd == CMD_READ) begin
                            r_job.is_add    <= 1'b0;
                            r_job.in_range  <= (32'(i_item.read_bin) < NUM_BINS);
                            r_job.bin_index <= i_item.read_bin;
                            r_job.addr      <= BIN_AW'(i_item.read_bin);
                            r_state         <= S_SEND;
                        end else begin
                            r_quo   <= n_sample;
                            r_rem   <= '0;
                            r_div   <= r_bin_width;
                            r_step  <= STEP_W'(SAMPLE_W - 1);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_job.is_add    <= 1'b1;
                        r_job.in_range  <= 1'b1;
                        r_job.bin_index <= BIN_IDX_W'(n_bin);
                        r_job.addr      <= BIN_AW'(n_bin);
                        r_state         <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (!i_job_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hdl/fwh_job_q.sv
module fwh_job_q (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fwh_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output fwh_pkg::t_job o_job,
    output logic          o_empty
);
    import fwh_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

>>> hdl/fwh_back.sv
`include "fixed_width_histogram_unit_assert.svh"

module fwh_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_empty,
    input  fwh_pkg::t_job     i_job,
    output logic              o_job_pop,
    output logic              o_clearing,
    output logic              empty,
    input  logic              pop,
    output fwh_pkg::t_out_item o_item
);
    import fwh_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_UPD} t_state;

    t_state               r_state;
    logic [BIN_AW-1:0]    r_clr_addr;
    t_job                 r_job;
    logic [COUNT_W-1:0]   r_rd_data;
    logic [COUNT_W-1:0]   r_mem [NUM_BINS];

    t_out_item            r_oq [QDEPTH];
    logic [QPTR_W-1:0]    r_oq_wr;
    logic [QPTR_W-1:0]    r_oq_rd;
    logic [QCNT_W-1:0]    r_oq_cnt;

    logic                 mem_we;
    logic [BIN_AW-1:0]    mem_wa;
    logic [COUNT_W-1:0]   mem_wd;
    logic [COUNT_W-1:0]   n_count;
    logic                 res_push;
    logic                 res_pop;
    t_out_item            n_res;

    assign o_clearing = (r_state == S_CLEAR);
    assign o_job_pop  = (r_state == S_IDLE) && !i_job_empty
                     && (r_oq_cnt != QCNT_W'(QDEPTH));
    assign res_push   = (r_state == S_UPD);
    assign empty      = (r_oq_cnt == '0);
    assign res_pop    = pop && !empty;
    assign o_item     = r_oq[r_oq_rd];

    // saturating increment on add, plain read otherwise; an out-of-range read gives zero
    always_comb begin
        if (!r_job.in_range) begin
            n_count = '0;
        end else if (r_job.is_add && (r_rd_data != '1)) begin
            n_count = r_rd_data + 1'b1;
        end else begin
            n_count = r_rd_data;
        end
        n_res.bin_index = r_job.bin_index;
        n_res.bin_count = n_count;
        n_res.saturated = (n_count == '1);
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else begin
            mem_we = (r_state == S_UPD) && r_job.is_add && r_job.in_range;
            mem_wa = r_job.addr;
            mem_wd = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_rd_data <= r_mem[i_job.addr];
            r_job     <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_oq[r_oq_wr] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_oq_wr    <= '0;
            r_oq_rd    <= '0;
            r_oq_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == BIN_AW'(NUM_BINS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (res_push) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (res_pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + QCNT_W'(res_push) - QCNT_W'(res_pop);
        end
    end

    // a job is only taken when its result has a slot waiting
    `FWH_ASSERT_IMP(a_pop_has_room, o_job_pop, r_oq_cnt < QCNT_W'(QDEPTH))
    `FWH_ASSERT_IMP(a_oq_bound, 1'b1, r_oq_cnt <= QCNT_W'(QDEPTH))
    `FWH_ASSERT_IMP(a_no_job_in_clear, r_state == S_CLEAR, !o_job_pop && !res_push)
    `FWH_ASSERT_IMP(a_sat_flag, !empty, o_item.saturated == (o_item.bin_count == '1))
    `FWH_ASSERT_NXT(a_pop_then_upd, o_job_pop, r_state == S_UPD)

endmodule

>>> hdl/fixed_width_histogram_unit.sv
// Flow: an add goes through the 14 divide steps, the hand-off to the job queue, the bin
//   read and the update before it reaches the result ports; a read skips the divide.
// The front holds one item at a time and takes no new one until the last is handed off;
//   an add is paced by its one-bit-per-cycle divider. The back reads a bin, then writes it.
// Reset: synchronous, active low. Afterwards a pass zeroes the bin store, one bin a
//   cycle; full stays high until it finishes. bin_width resets to 100.
module fixed_width_histogram_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: bin width
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fwh_pkg::SAMPLE_W-1:0]  i_cfg_data,
    // item input queue
    input  logic                          push,
    output logic                          full,
    input  fwh_pkg::t_in_item             i_item,
    // result output queue
    output logic                          empty,
    input  logic                          pop,
    output fwh_pkg::t_out_item            o_item
);
    import fwh_pkg::*;

    // front -> job queue
    logic jq_push;
    t_job jq_in;
    logic jq_full;
    // job queue -> back
    logic jq_pop;
    t_job jq_out;
    logic jq_empty;
    // back is sweeping the store after reset
    logic clearing;

    // Front: takes items, clamps the sample and divides it by the bin width
    // (restoring, 14 steps), clamps the quotient to the last bin. Reads skip
    // the divider. One item in flight here at a time.
    fwh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_clearing  (clearing),
        .o_job_push  (jq_push),
        .o_job       (jq_in),
        .i_job_full  (jq_full)
    );

    // Two-entry queue so the divider can start on the next item while the
    // back waits on a stalled result side.
    fwh_job_q u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (jq_push),
        .i_job   (jq_in),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_job   (jq_out),
        .o_empty (jq_empty)
    );

    // Back: owns the 1024 x 32 count RAM, does the saturating
    // read-modify-write and queues results (two-entry output queue).
    fwh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (jq_empty),
        .i_job       (jq_out),
        .o_job_pop   (jq_pop),
        .o_clearing  (clearing),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item)
    );

endmodule
